@@ rtl/core/dosb_pkg.sv @@
// Package with the types, constants and codes shared by the send buffer core.
`timescale 1ns / 1ps

package dosb_pkg;

  // Number of entries the buffer can hold.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SCAN_W = $clog2(DEPTH + 1);

  // Fixed field widths.
  localparam int TIME_W = 32;
  localparam int DELAY_W = 22;
  localparam int HANDLE_W = 16;
  localparam int PORT_W = 4;
  localparam int ENTRY_COUNT_W = 5;

  // Arithmetic constants.
  localparam logic [TIME_W-1:0] MS_PER_S = 32'd1000;
  localparam logic [TIME_W-1:0] MAX_DELAY_MS = 32'h7FFF_FFFF;
  localparam logic [TIME_W-1:0] SIGN_BIT = 32'h8000_0000;
  localparam logic signed [TIME_W-1:0] TTN_EMPTY = -32'sd1;
  localparam logic signed [TIME_W-1:0] TTN_MIN = 32'sd1;

  // Command codes; any other code acts as a query.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_REMOVE
  } state_t;

  // One stored entry.
  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [HANDLE_W-1:0] handle;
    logic [PORT_W-1:0]   port;
  } entry_t;

  // Running best entry that travels down the chain during a search.
  typedef struct packed {
    logic                valid;
    logic [TIME_W-1:0]   key;
    logic [IDX_W-1:0]    idx;
    logic [HANDLE_W-1:0] handle;
    logic [PORT_W-1:0]   port;
  } cand_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    entry_t            wr_entry;
    logic              shift_en;
    logic [IDX_W-1:0]  shift_idx;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] now;
  } cell_ctrl_t;

  // Command payload.
  typedef struct packed {
    logic [1:0]          command;
    logic [TIME_W-1:0]   now_ms;
    logic [DELAY_W-1:0]  delay;
    logic                delay_in_seconds;
    logic [HANDLE_W-1:0] packet_handle;
    logic [PORT_W-1:0]   out_port;
  } request_t;

  // Result payload.
  typedef struct packed {
    logic                     popped_valid;
    logic [HANDLE_W-1:0]      popped_handle;
    logic [PORT_W-1:0]        popped_port;
    logic                     add_dropped;
    logic signed [TIME_W-1:0] time_to_next;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } result_t;

endpackage

@@ rtl/core/deadline_ordered_send_buffer_core.sv @@
// Top level of the deadline-ordered send buffer: sequencer plus the chain of entry cells.
`timescale 1ns / 1ps

// Stores up to DEPTH packet handles with deadlines and hands them out earliest deadline
// first, oldest first among equal deadlines. A command transfers on a rising edge with
// start high and busy low; its single result appears on result for exactly one cycle with
// done high and must be taken then, since there is no backpressure. The earliest entry is
// found by a candidate that moves one cell per cycle down the chain; an add or a query runs
// one search between transfer and done, and a pop that removes an entry runs two searches,
// one before and one after the removal.
// busy falls in the cycle done is high, so the next command can transfer in that cycle.
// No clearing pass follows reset.
module deadline_ordered_send_buffer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dosb_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output dosb_pkg::result_t  result
);

  dosb_pkg::cell_ctrl_t cell_ctrl;
  dosb_pkg::entry_t     entries [dosb_pkg::DEPTH];
  dosb_pkg::cand_t      cands   [dosb_pkg::DEPTH];

  // Command sequencing and result formatting.
  dosb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cell_ctrl (cell_ctrl),
    .best      (cands[dosb_pkg::DEPTH-1])
  );

  // Chain of cells in insertion order; the search candidate flows from cell 0 upward.
  for (genvar i = 0; i < dosb_pkg::DEPTH; i++) begin : g_cell
    dosb_pkg::entry_t neighbor;
    dosb_pkg::cand_t  cand_in;

    if (i == dosb_pkg::DEPTH - 1) begin : g_last
      assign neighbor = entries[i];
    end else begin : g_mid
      assign neighbor = entries[i+1];
    end

    if (i == 0) begin : g_first
      assign cand_in = '0;
    end else begin : g_rest
      assign cand_in = cands[i-1];
    end

    dosb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (dosb_pkg::IDX_W'(i)),
      .ctrl     (cell_ctrl),
      .neighbor (neighbor),
      .cand_in  (cand_in),
      .entry    (entries[i]),
      .cand_out (cands[i])
    );
  end

endmodule

@@ rtl/core/dosb_cell.sv @@
// One cell of the entry chain: holds an entry and takes part in the earliest-deadline search.
`timescale 1ns / 1ps

module dosb_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dosb_pkg::IDX_W-1:0] cell_idx,
  input  dosb_pkg::cell_ctrl_t       ctrl,
  input  dosb_pkg::entry_t           neighbor,
  input  dosb_pkg::cand_t            cand_in,
  output dosb_pkg::entry_t           entry,
  output dosb_pkg::cand_t            cand_out
);

  logic                        occupied;
  logic [dosb_pkg::TIME_W-1:0] key;
  logic                        take_own;
  dosb_pkg::cand_t             cand_next;

  // Entry storage: a new entry is written here, or the upper neighbor slides down on a removal.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (ctrl.wr_idx == cell_idx)) begin
      entry <= ctrl.wr_entry;
    end else if (ctrl.shift_en && (cell_idx >= ctrl.shift_idx)) begin
      entry <= neighbor;
    end
  end

  // The key is the wrapped distance to the deadline, biased so an unsigned compare orders it.
  always_comb begin
    occupied = dosb_pkg::CNT_W'(cell_idx) < ctrl.count;
    key      = (entry.deadline - ctrl.now) ^ dosb_pkg::SIGN_BIT;
    // A strictly smaller key wins, so on a tie the earlier cell keeps the lead.
    take_own = occupied && (!cand_in.valid || (key < cand_in.key));
    if (take_own) begin
      cand_next.valid  = 1'b1;
      cand_next.key    = key;
      cand_next.idx    = cell_idx;
      cand_next.handle = entry.handle;
      cand_next.port   = entry.port;
    end else begin
      cand_next = cand_in;
    end
  end

  // Hand the better candidate on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.valid <= 1'b0;
    end else begin
      cand_out <= cand_next;
    end
  end

endmodule

@@ rtl/core/dosb_ctrl.sv @@
// Command sequencer: entry count, deadline arithmetic, search timing and the result register.
`timescale 1ns / 1ps

module dosb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  dosb_pkg::request_t   request,
  output logic                 busy,
  output logic                 done,
  output dosb_pkg::result_t    result,
  output dosb_pkg::cell_ctrl_t cell_ctrl,
  input  dosb_pkg::cand_t      best
);

  dosb_pkg::state_t                state;
  dosb_pkg::state_t                state_next;
  logic [dosb_pkg::CNT_W-1:0]      count;
  logic [dosb_pkg::SCAN_W-1:0]     scan_cnt;
  logic [1:0]                      cmd;
  logic [dosb_pkg::TIME_W-1:0]     now_q;
  logic [dosb_pkg::TIME_W-1:0]     ms_prod;
  logic [dosb_pkg::HANDLE_W-1:0]   handle_q;
  logic [dosb_pkg::PORT_W-1:0]     port_q;
  logic                            pop_pending;
  logic                            dropped;
  logic                            popped_valid;
  logic [dosb_pkg::HANDLE_W-1:0]   popped_handle;
  logic [dosb_pkg::PORT_W-1:0]     popped_port;
  logic [dosb_pkg::IDX_W-1:0]      remove_idx;

  logic                            accept;
  logic                            full;
  logic                            scan_done;
  logic                            do_remove;
  logic [dosb_pkg::TIME_W-1:0]     ms_mult;
  logic [dosb_pkg::TIME_W-1:0]     ms_sat;
  logic [dosb_pkg::TIME_W-1:0]     gap_ms;
  logic signed [dosb_pkg::TIME_W-1:0] ttn;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      dosb_pkg::ST_IDLE: begin
        if (start) begin
          state_next = dosb_pkg::ST_WRITE;
        end
      end
      dosb_pkg::ST_WRITE: begin
        state_next = dosb_pkg::ST_SCAN;
      end
      dosb_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = do_remove ? dosb_pkg::ST_REMOVE : dosb_pkg::ST_IDLE;
        end
      end
      dosb_pkg::ST_REMOVE: begin
        state_next = dosb_pkg::ST_SCAN;
      end
      default: begin
        state_next = dosb_pkg::ST_IDLE;
      end
    endcase
  end

  // Output and cell control logic.
  always_comb begin
    busy      = (state != dosb_pkg::ST_IDLE);
    accept    = start && !busy;
    full      = (count >= dosb_pkg::CNT_W'(dosb_pkg::DEPTH));
    scan_done = (state == dosb_pkg::ST_SCAN) &&
                (scan_cnt == dosb_pkg::SCAN_W'(dosb_pkg::DEPTH));
    do_remove = pop_pending && best.valid;

    cell_ctrl.wr_en             = (state == dosb_pkg::ST_WRITE) &&
                                  (cmd == dosb_pkg::CMD_ADD) && !full;
    cell_ctrl.wr_idx            = count[dosb_pkg::IDX_W-1:0];
    cell_ctrl.wr_entry.deadline = now_q + ms_sat;
    cell_ctrl.wr_entry.handle   = handle_q;
    cell_ctrl.wr_entry.port     = port_q;
    cell_ctrl.shift_en          = (state == dosb_pkg::ST_REMOVE);
    cell_ctrl.shift_idx         = remove_idx;
    cell_ctrl.count             = count;
    cell_ctrl.now               = now_q;
  end

  // Delay in ms: one constant multiply at acceptance, saturation on the registered product in the next cycle.
  always_comb begin
    ms_mult = request.delay_in_seconds ?
              dosb_pkg::TIME_W'(request.delay) * dosb_pkg::MS_PER_S :
              dosb_pkg::TIME_W'(request.delay);
    ms_sat  = (ms_prod > dosb_pkg::MAX_DELAY_MS) ? dosb_pkg::MAX_DELAY_MS : ms_prod;
  end

  // Time to the next deadline from the search winner; passed deadlines read as one.
  always_comb begin
    gap_ms = best.key ^ dosb_pkg::SIGN_BIT;
    if (!best.valid) begin
      ttn = dosb_pkg::TTN_EMPTY;
    end else if (gap_ms[dosb_pkg::TIME_W-1] || (gap_ms <= dosb_pkg::TIME_W'(1))) begin
      ttn = dosb_pkg::TTN_MIN;
    end else begin
      ttn = $signed(gap_ms);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dosb_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= scan_done && !do_remove;
      if (cell_ctrl.wr_en) begin
        count <= count + dosb_pkg::CNT_W'(1);
      end else if (cell_ctrl.shift_en) begin
        count <= count - dosb_pkg::CNT_W'(1);
      end
    end
  end

  // Command capture, search counter and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd           <= request.command;
      now_q         <= request.now_ms;
      ms_prod       <= ms_mult;
      handle_q      <= request.packet_handle;
      port_q        <= request.out_port;
      pop_pending   <= (request.command == dosb_pkg::CMD_POP);
      dropped       <= 1'b0;
      popped_valid  <= 1'b0;
      popped_handle <= '0;
      popped_port   <= '0;
    end
    if (state == dosb_pkg::ST_WRITE) begin
      dropped <= (cmd == dosb_pkg::CMD_ADD) && full;
    end
    if ((state == dosb_pkg::ST_WRITE) || (state == dosb_pkg::ST_REMOVE)) begin
      scan_cnt <= '0;
    end else if (state == dosb_pkg::ST_SCAN) begin
      scan_cnt <= scan_cnt + dosb_pkg::SCAN_W'(1);
    end
    if (scan_done && do_remove) begin
      pop_pending   <= 1'b0;
      popped_valid  <= 1'b1;
      popped_handle <= best.handle;
      popped_port   <= best.port;
      remove_idx    <= best.idx;
    end
    if (scan_done && !do_remove) begin
      result.popped_valid  <= popped_valid;
      result.popped_handle <= popped_handle;
      result.popped_port   <= popped_port;
      result.add_dropped   <= dropped;
      result.time_to_next  <= ttn;
      result.entry_count   <= dosb_pkg::ENTRY_COUNT_W'(count);
    end
  end

`ifndef SYNTHESIS
  // The count never goes past the capacity.
  assert property (@(posedge clk) disable iff (rst)
    count <= dosb_pkg::CNT_W'(dosb_pkg::DEPTH))
    else $error("entry count exceeds capacity");

  // An accepted command makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // A result is reported only after a search has ended.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == dosb_pkg::ST_SCAN) && !busy)
    else $error("result strobe outside of a search end");

  // An empty buffer and a time of minus one always go together.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.time_to_next == dosb_pkg::TTN_EMPTY) ==
              (result.entry_count == '0)))
    else $error("time to next deadline disagrees with entry count");

  // A pop and a dropped add never show up in the same result.
  assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.popped_valid && result.add_dropped))
    else $error("pop and dropped add reported together");
`endif

endmodule
